// ===== src/motor_feedback_frame_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frame decoder. They expect
// signals named clock and reset in the scope of use.
// ----------------------------------------------------------------------------
`ifndef MOTOR_FEEDBACK_FRAME_DECODER_DEFINES_SVH
`define MOTOR_FEEDBACK_FRAME_DECODER_DEFINES_SVH

// same-cycle implication
`define MFD_ASSERT_NOW(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication
`define MFD_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ===== src/mfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame decoder package
// Widths, frame identifiers, register indexes, reset values and the structs
// passed between the decoder modules.
// ----------------------------------------------------------------------------
package mfd_pkg;

   localparam int ENCODER_COUNTS = 8192;

   localparam int ID_W     = 11;
   localparam int WORD_W   = 16;
   localparam int SLOT_W   = 3;
   localparam int CENTRE_W = 13;

   localparam int REQ_TDATA_W = 3 * WORD_W;
   localparam int REQ_TUSER_W = ID_W;
   localparam int RSP_FIELD_W = 4 * WORD_W + CENTRE_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_FIELD_W;
   localparam int RSP_TUSER_W = SLOT_W;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 17;

   localparam int MUL_A_W   = 17;
   localparam int MUL_B_W   = 17;
   localparam int MUL_P_W   = MUL_A_W + 1 + MUL_B_W;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);

   localparam logic [ID_W-1:0] ID_WHEEL_FIRST = 11'h201;
   localparam logic [ID_W-1:0] ID_WHEEL_LAST  = 11'h204;
   localparam logic [ID_W-1:0] ID_YAW         = 11'h205;
   localparam logic [ID_W-1:0] ID_PITCH       = 11'h206;
   localparam logic [ID_W-1:0] ID_FEEDER      = 11'h207;

   localparam logic [SLOT_W-1:0] SLOT_YAW    = 3'd4;
   localparam logic [SLOT_W-1:0] SLOT_PITCH  = 3'd5;
   localparam logic [SLOT_W-1:0] SLOT_FEEDER = 3'd6;

   localparam logic [CSR_INDEX_W-1:0] REG_YAW_OFFSET     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PITCH_OFFSET   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_WRAP_THRESHOLD = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_LENGTH  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SMOOTHING      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_PITCH_GAIN     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_YAW_GAIN       = 3'd6;

   typedef struct packed {
      logic [12:0] yaw_offset;
      logic [12:0] pitch_offset;
      logic [11:0] wrap_threshold;
      logic [3:0]  window_length;
      logic [16:0] smoothing_q16;
      logic [15:0] pitch_rate_gain_q8;
      logic [7:0]  yaw_rate_gain;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      yaw_offset:         13'd6845,
      pitch_offset:       13'd5800,
      wrap_threshold:     12'd100,
      window_length:      4'd5,
      smoothing_q16:      17'd58982,
      pitch_rate_gain_q8: 16'd2250,
      yaw_rate_gain:      8'd6
   };

   typedef struct packed {
      logic                      start;
      logic signed [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0]        b;
   } mul_req_type;

   typedef struct packed {
      logic                      done;
      logic signed [MUL_P_W-1:0] product;
   } mul_rsp_type;

   typedef struct packed {
      logic [SLOT_W-1:0]          motor_slot;
      logic [WORD_W-1:0]          raw_angle;
      logic signed [WORD_W-1:0]   motor_speed;
      logic signed [WORD_W-1:0]   motor_current;
      logic signed [CENTRE_W-1:0] centred_angle;
      logic signed [WORD_W-1:0]   angular_rate;
   } result_type;

endpackage

// ===== src/mfd_csr.sv =====
// ----------------------------------------------------------------------------
// Frame decoder configuration registers
// Holds the offsets, unwrap threshold, window length and gains; one write
// beat per cycle, indexes beyond the register list are dropped.
// ----------------------------------------------------------------------------
module mfd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mfd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mfd_pkg::CSR_DATA_W-1:0]     csr_data,
   output mfd_pkg::cfg_type                   cfg
);
   import mfd_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_YAW_OFFSET:     cfg_in.yaw_offset         = csr_data[12:0];
            REG_PITCH_OFFSET:   cfg_in.pitch_offset       = csr_data[12:0];
            REG_WRAP_THRESHOLD: cfg_in.wrap_threshold     = csr_data[11:0];
            REG_WINDOW_LENGTH:  cfg_in.window_length      = csr_data[3:0];
            REG_SMOOTHING:      cfg_in.smoothing_q16      = csr_data[16:0];
            REG_PITCH_GAIN:     cfg_in.pitch_rate_gain_q8 = csr_data[15:0];
            REG_YAW_GAIN:       cfg_in.yaw_rate_gain      = csr_data[7:0];
            default:            cfg_in                    = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== src/mfd_serial_mul.sv =====
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Signed multiplicand times unsigned multiplier, one multiplier bit per
// cycle, LSB first, through a right-shifting product register.
// ----------------------------------------------------------------------------
`include "motor_feedback_frame_decoder_defines.svh"

module mfd_serial_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  mfd_pkg::mul_req_type mul_req,
   output mfd_pkg::mul_rsp_type mul_rsp
);
   import mfd_pkg::*;

   localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(MUL_B_W - 1);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [MUL_CNT_W-1:0]      count_ff, count_in;
   logic signed [MUL_A_W-1:0] a_ff, a_in;
   logic [MUL_P_W-1:0]        prod_ff, prod_in;
   logic [MUL_A_W:0]          hi;
   logic [MUL_A_W+1:0]        sum;

   always_comb begin
      hi       = prod_ff[MUL_P_W-1 -: MUL_A_W+1];
      sum      = {hi[MUL_A_W], hi}
               + (prod_ff[0] ? {{2{a_ff[MUL_A_W-1]}}, a_ff} : '0);
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      a_in     = a_ff;
      prod_in  = prod_ff;
      if (mul_req.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         a_in     = mul_req.a;
         prod_in  = {{(MUL_A_W+1){1'b0}}, mul_req.b};
      end else if (busy_ff) begin
         prod_in  = {sum, prod_ff[MUL_B_W-1:1]};
         count_in = count_ff + 1'b1;
         if (count_ff == MUL_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      prod_ff <= prod_in;
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = prod_ff;

   `MFD_ASSERT_NOW(a_mul_start_idle, mul_req.start, !busy_ff, "multiply started while busy")
   `MFD_ASSERT_NOW(a_mul_done_idle, done_ff, !busy_ff, "done raised while still shifting")
   `MFD_ASSERT_NEXT(a_mul_last_done, busy_ff && !mul_req.start && count_ff == MUL_LAST,
      done_ff && !busy_ff, "last step did not finish the product")

endmodule

// ===== src/mfd_core.sv =====
// ----------------------------------------------------------------------------
// Frame decoder sequencer
// Decodes the frame identifier, unwraps and windows the pitch encoder,
// drives the serial multiplier for smoothing and rates, builds the result.
// ----------------------------------------------------------------------------
`include "motor_feedback_frame_decoder_defines.svh"

module mfd_core (
   input  logic                         clock,
   input  logic                         reset,
   input  mfd_pkg::cfg_type             cfg,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [mfd_pkg::ID_W-1:0]     req_frame_id,
   input  logic [mfd_pkg::WORD_W-1:0]   req_word0,
   input  logic [mfd_pkg::WORD_W-1:0]   req_word1,
   input  logic [mfd_pkg::WORD_W-1:0]   req_word2,
   output mfd_pkg::mul_req_type         mul_req,
   input  mfd_pkg::mul_rsp_type         mul_rsp,
   input  logic                         out_free,
   output logic                         res_valid,
   output mfd_pkg::result_type          result
);
   import mfd_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_YAW_MUL, S_YAW_WAIT, S_P_DELTA, S_P_UNWRAP, S_P_ACCUM,
      S_P_MIX, S_MIX_WAIT, S_P_SMOOTH, S_P_RATE, S_RATE_WAIT, S_EMIT
   } state_type;

   typedef enum logic [1:0] {K_WHEEL, K_YAW, K_PITCH, K_FEEDER} kind_type;

   localparam logic signed [17:0] ENC_COUNT = 18'(ENCODER_COUNTS);
   localparam logic signed [17:0] ENC_HALF  = 18'(ENCODER_COUNTS / 2 - 1);
   localparam logic signed [17:0] ENC_WRAP  = 18'(ENCODER_COUNTS - 1);
   localparam logic [16:0]        W_ONE     = 17'(65536);

   function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
      logic signed [15:0] r;
      if (v > 36'sd32767) r = 16'sh7fff;
      else if (v < -36'sd32768) r = 16'sh8000;
      else r = v[15:0];
      return r;
   endfunction

   function automatic logic signed [19:0] sat20(input logic signed [20:0] v);
      logic signed [19:0] r;
      if (v > 21'sd524287) r = 20'sh7ffff;
      else if (v < -21'sd524288) r = 20'sh80000;
      else r = v[19:0];
      return r;
   endfunction

   function automatic logic signed [12:0] sat13(input logic signed [17:0] v);
      logic signed [12:0] r;
      if (v > 18'sd4095) r = 13'sh0fff;
      else if (v < -18'sd4096) r = 13'sh1000;
      else r = v[12:0];
      return r;
   endfunction

   state_type          state_ff, state_in;
   kind_type           kind_ff, kind_in;
   logic [15:0]        prev_ff, prev_in;
   logic signed [19:0] sum_ff, sum_in;
   logic [3:0]         count_ff, count_in;
   logic signed [15:0] held_ff, held_in;
   logic signed [15:0] smoothed_ff, smoothed_in;

   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [15:0]        w0_ff, w0_in;
   logic signed [15:0] s1_ff, s1_in;
   logic signed [15:0] s2_ff, s2_in;
   logic signed [17:0] c_ff, c_in;
   logic signed [15:0] rate_ff, rate_in;
   logic signed [16:0] d_ff, d_in;
   logic signed [17:0] add_ff, add_in;
   logic signed [35:0] mix_ff, mix_in;

   logic               in_fire;
   logic signed [16:0] thr;
   logic               small_step;
   logic signed [20:0] sum_wide;
   logic signed [19:0] sum_sat;
   logic [3:0]         count_inc;
   logic [16:0]        w_eff;
   logic signed [16:0] mix_a;
   logic signed [35:0] prod36;
   logic signed [35:0] mix_adj;
   logic signed [35:0] rate_adj;
   logic signed [17:0] c_wrap;
   logic signed [12:0] centred;
   logic [12:0]        offset_sel;

   assign req_tready = (state_ff == S_IDLE);
   assign in_fire    = req_tvalid && req_tready;
   assign res_valid  = (state_ff == S_EMIT);

   always_comb begin
      thr        = signed'({5'b0, cfg.wrap_threshold});
      small_step = (d_ff < thr) && (d_ff > -thr);
      sum_wide   = {sum_ff[19], sum_ff} + {{3{add_ff[17]}}, add_ff};
      sum_sat    = sat20(sum_wide);
      count_inc  = count_ff + 1'b1;
      w_eff      = (cfg.smoothing_q16 > W_ONE) ? W_ONE : cfg.smoothing_q16;
      mix_a      = {held_ff[15], held_ff} - {smoothed_ff[15], smoothed_ff};
      prod36     = {mul_rsp.product[MUL_P_W-1], mul_rsp.product};
      mix_adj    = mix_ff + (mix_ff[35] ? 36'sd65535 : 36'sd0);
      rate_adj   = prod36 + (prod36[35] ? 36'sd255 : 36'sd0);
      offset_sel = (req_frame_id == ID_PITCH) ? cfg.pitch_offset : cfg.yaw_offset;
      if (c_ff > ENC_HALF) c_wrap = c_ff - ENC_WRAP;
      else if (c_ff < -ENC_HALF) c_wrap = c_ff + ENC_WRAP;
      else c_wrap = c_ff;
      centred = sat13(c_wrap);
   end

   // multiplier operands by state
   always_comb begin
      mul_req.start = (state_ff == S_YAW_MUL) || (state_ff == S_P_MIX)
                   || (state_ff == S_P_RATE);
      unique case (state_ff)
         S_YAW_MUL: begin
            mul_req.a = {s1_ff[15], s1_ff};
            mul_req.b = {9'b0, cfg.yaw_rate_gain};
         end
         S_P_MIX: begin
            mul_req.a = mix_a;
            mul_req.b = w_eff;
         end
         S_P_RATE: begin
            mul_req.a = {smoothed_ff[15], smoothed_ff};
            mul_req.b = {1'b0, cfg.pitch_rate_gain_q8};
         end
         default: begin
            mul_req.a = '0;
            mul_req.b = '0;
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      prev_in     = prev_ff;
      sum_in      = sum_ff;
      count_in    = count_ff;
      held_in     = held_ff;
      smoothed_in = smoothed_ff;
      slot_in     = slot_ff;
      w0_in       = w0_ff;
      s1_in       = s1_ff;
      s2_in       = s2_ff;
      c_in        = c_ff;
      rate_in     = rate_ff;
      d_in        = d_ff;
      add_in      = add_ff;
      mix_in      = mix_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (in_fire) begin
               w0_in = req_word0;
               s1_in = req_word1;
               s2_in = req_word2;
               c_in  = {2'b0, req_word0} - {5'b0, offset_sel};
               priority if (req_frame_id >= ID_WHEEL_FIRST
                            && req_frame_id <= ID_WHEEL_LAST) begin
                  kind_in  = K_WHEEL;
                  slot_in  = SLOT_W'(req_frame_id - ID_WHEEL_FIRST);
                  state_in = S_EMIT;
               end else if (req_frame_id == ID_YAW) begin
                  kind_in  = K_YAW;
                  slot_in  = SLOT_YAW;
                  state_in = S_YAW_MUL;
               end else if (req_frame_id == ID_PITCH) begin
                  kind_in  = K_PITCH;
                  slot_in  = SLOT_PITCH;
                  state_in = S_P_DELTA;
               end else if (req_frame_id == ID_FEEDER) begin
                  kind_in  = K_FEEDER;
                  slot_in  = SLOT_FEEDER;
                  state_in = S_EMIT;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_YAW_MUL: state_in = S_YAW_WAIT;
         S_YAW_WAIT: begin
            if (mul_rsp.done) begin
               rate_in  = sat16(prod36);
               state_in = S_EMIT;
            end
         end
         S_P_DELTA: begin
            d_in     = {1'b0, w0_ff} - {1'b0, prev_ff};
            state_in = S_P_UNWRAP;
         end
         S_P_UNWRAP: begin
            if (small_step) add_in = {d_ff[16], d_ff};
            else if (d_ff < 17'sd0) add_in = {d_ff[16], d_ff} + ENC_COUNT;
            else if (d_ff > 17'sd0) add_in = {d_ff[16], d_ff} - ENC_COUNT;
            else add_in = '0;
            state_in = S_P_ACCUM;
         end
         S_P_ACCUM: begin
            prev_in = w0_ff;
            if (count_inc >= cfg.window_length) begin
               count_in = '0;
               sum_in   = '0;
               held_in  = sat16({{16{sum_sat[19]}}, sum_sat});
            end else begin
               count_in = count_inc;
               sum_in   = sum_sat;
            end
            state_in = S_P_MIX;
         end
         S_P_MIX: state_in = S_MIX_WAIT;
         S_MIX_WAIT: begin
            if (mul_rsp.done) begin
               mix_in   = prod36 + {{4{smoothed_ff[15]}}, smoothed_ff, 16'b0};
               state_in = S_P_SMOOTH;
            end
         end
         S_P_SMOOTH: begin
            smoothed_in = sat16(mix_adj >>> 16);
            state_in    = S_P_RATE;
         end
         S_P_RATE: state_in = S_RATE_WAIT;
         S_RATE_WAIT: begin
            if (mul_rsp.done) begin
               rate_in  = sat16(rate_adj >>> 8);
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         kind_ff     <= K_WHEEL;
         prev_ff     <= '0;
         sum_ff      <= '0;
         count_ff    <= '0;
         held_ff     <= '0;
         smoothed_ff <= '0;
      end else begin
         state_ff    <= state_in;
         kind_ff     <= kind_in;
         prev_ff     <= prev_in;
         sum_ff      <= sum_in;
         count_ff    <= count_in;
         held_ff     <= held_in;
         smoothed_ff <= smoothed_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      w0_ff   <= w0_in;
      s1_ff   <= s1_in;
      s2_ff   <= s2_in;
      c_ff    <= c_in;
      rate_ff <= rate_in;
      d_ff    <= d_in;
      add_ff  <= add_in;
      mix_ff  <= mix_in;
   end

   always_comb begin
      result.motor_slot = slot_ff;
      unique case (kind_ff)
         K_WHEEL: begin
            result.raw_angle     = '0;
            result.motor_speed   = s1_ff;
            result.motor_current = '0;
            result.centred_angle = '0;
            result.angular_rate  = '0;
         end
         K_YAW: begin
            result.raw_angle     = w0_ff;
            result.motor_speed   = s1_ff;
            result.motor_current = s2_ff;
            result.centred_angle = centred;
            result.angular_rate  = rate_ff;
         end
         K_PITCH: begin
            result.raw_angle     = w0_ff;
            result.motor_speed   = smoothed_ff;
            result.motor_current = s1_ff;
            result.centred_angle = centred;
            result.angular_rate  = rate_ff;
         end
         default: begin
            result.raw_angle     = w0_ff;
            result.motor_speed   = s1_ff;
            result.motor_current = s2_ff;
            result.centred_angle = '0;
            result.angular_rate  = '0;
         end
      endcase
   end

   `MFD_ASSERT_NOW(a_core_done_wait, mul_rsp.done,
      state_ff == S_YAW_WAIT || state_ff == S_MIX_WAIT || state_ff == S_RATE_WAIT,
      "product arrived outside a wait state")
   `MFD_ASSERT_NEXT(a_core_emit_hold, state_ff == S_EMIT && !out_free,
      state_ff == S_EMIT, "result dropped while output busy")
   `MFD_ASSERT_NEXT(a_core_smooth_only, state_ff != S_P_SMOOTH,
      $stable(smoothed_ff), "smoothed velocity changed outside update")

endmodule

// ===== src/motor_feedback_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// Motor feedback frame decoder
// Decodes one motor feedback frame per request beat into one result beat
// with slot, angle, speed, current, centred angle and rate.
// ----------------------------------------------------------------------------
// A request beat carries the frame identifier in req_tuser and the three
// payload words in req_tdata; identifiers outside 0x201-0x207 are consumed
// and give no result. Wheel and feeder frames need no multiply; yaw and
// pitch frames wait on the 17-step bit-serial multiplier, used once for
// the yaw rate and twice for pitch (smoothing, then rate). A new frame is
// accepted only after the previous result has left the core. A finished
// result sits in the output register, so the next frame is accepted while
// it waits for rsp_tready. Configuration writes are taken every cycle and
// belong to quiet periods between frames.
module motor_feedback_frame_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mfd_pkg::REQ_TDATA_W-1:0]     req_tdata,  // word0, word1, word2
   input  logic [mfd_pkg::REQ_TUSER_W-1:0]     req_tuser,  // frame_id
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // raw_angle, motor_speed, motor_current, centred_angle, angular_rate, pad
   output logic [mfd_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic [mfd_pkg::RSP_TUSER_W-1:0]     rsp_tuser,  // motor_slot
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mfd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mfd_pkg::CSR_DATA_W-1:0]      csr_data
);
   import mfd_pkg::*;

   cfg_type     cfg;
   mul_req_type mul_req;
   mul_rsp_type mul_rsp;
   result_type  result;
   logic        res_valid;
   logic        out_free;
   logic        load;

   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff, rsp_data_in;

   mfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mfd_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   mfd_core u_core (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_frame_id (req_tuser[ID_W-1:0]),
      .req_word0    (req_tdata[WORD_W-1:0]),
      .req_word1    (req_tdata[2*WORD_W-1:WORD_W]),
      .req_word2    (req_tdata[3*WORD_W-1:2*WORD_W]),
      .mul_req      (mul_req),
      .mul_rsp      (mul_rsp),
      .out_free     (out_free),
      .res_valid    (res_valid),
      .result       (result)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign load     = res_valid && out_free;

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.motor_slot;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}},
                        rsp_data_ff.angular_rate,
                        rsp_data_ff.centred_angle,
                        rsp_data_ff.motor_current,
                        rsp_data_ff.motor_speed,
                        rsp_data_ff.raw_angle};

endmodule
